@@ design/assert_macros.svh @@
// Assertion helpers used by the queue top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sequence violated");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ design/ipq_pkg.sv @@
package ipq_pkg;

  localparam int USER_W = 16;
  localparam int TASK_W = 16;
  localparam int PRIO_W = 31;

  typedef logic [USER_W-1:0] user_t;
  typedef logic [TASK_W-1:0] task_id_t;
  typedef logic [PRIO_W-1:0] prio_t;

  typedef struct packed {
    user_t    user_id;
    task_id_t task_id;
    prio_t    prio;
  } entry_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_EDIT   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_EXEC   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY,
    S_INSERT
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e op;
    entry_t   ins;
    prio_t    rm_prio;
    task_id_t rm_task;
    task_id_t look_task;
  } cell_ctrl_t;

  // True when key a sorts ahead of key b: higher priority, then higher id.
  function automatic logic ahead(prio_t pa, task_id_t ta, prio_t pb, task_id_t tb);
    logic r;
    if (pa != pb) begin
      r = pa > pb;
    end else begin
      r = ta > tb;
    end
    return r;
  endfunction

endpackage

@@ design/ipq_cell.sv @@
module ipq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic               clk,
  input  ipq_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]      count,
  input  ipq_pkg::entry_t    prev_ent,
  input  logic               prev_ahead,
  input  ipq_pkg::entry_t    next_ent,
  output ipq_pkg::entry_t    ent,
  output logic               ahead_new,
  output logic               match
);
  import ipq_pkg::*;

  localparam bit FIRST = (IDX == 0);

  logic valid;
  logic shift_out;

  assign valid     = CW'(IDX) < count;
  assign match     = valid && (ent.task_id == ctrl.look_task);
  // An empty cell counts as lying behind any new key.
  assign ahead_new = !valid || ahead(ctrl.ins.prio, ctrl.ins.task_id, ent.prio, ent.task_id);
  // On removal every cell at or behind the removed key takes its successor.
  assign shift_out = valid && !ahead(ent.prio, ent.task_id, ctrl.rm_prio, ctrl.rm_task);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD: begin
      end
      CELL_REMOVE: begin
        if (shift_out) begin
          ent <= next_ent;
        end
      end
      CELL_INSERT: begin
        if (ahead_new) begin
          ent <= (FIRST || !prev_ahead) ? ctrl.ins : prev_ent;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/ipq_find.sv @@
module ipq_find #(
  parameter int N  = 64,
  parameter int CW = 7
) (
  input  logic            clk,
  input  logic            load,
  input  logic            top_sel,
  input  logic [CW-1:0]   count,
  input  logic [N-1:0]    match,
  input  ipq_pkg::entry_t ents [N],
  output logic            hit,
  output ipq_pkg::entry_t found
);
  import ipq_pkg::*;

  logic   any;
  entry_t sel;

  // Task ids are unique, so at most one match bit is set.
  always_comb begin
    any = |match;
    sel = '0;
    for (int i = 0; i < N; i++) begin
      sel = entry_t'(sel | (ents[i] & {$bits(entry_t){match[i]}}));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (top_sel) begin
        hit   <= count != '0;
        found <= ents[0];
      end else begin
        hit   <= any;
        found <= sel;
      end
    end
  end

endmodule

@@ design/indexed_priority_task_queue_top.sv @@
// Each request passes the lookup and apply states, a successful edit also the reinsert
// state; the result is registered at the end of the last one. A new request is taken
// only as the last one finishes, as the id lookup is followed by the chain shift, and an
// unaccepted result stalls the sequencer. Reset (rst, synchronous, active high) empties
// the queue and clears the handshakes; entry contents are not cleared.
`include "assert_macros.svh"

module indexed_priority_task_queue_top #(
  parameter int MAX_TASKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // user_id[15:0], task_id[31:16], priority_req[62:32], zero
  input  logic [1:0]  s_tuser,  // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // status[2:0], top_user[18:3], zero
);
  import ipq_pkg::*;

  localparam int CW = $clog2(MAX_TASKS + 1);

  // The request being worked on is held here for the whole sequence.
  state_e        state, state_next;
  mode_e         req_mode;
  entry_t        req;
  logic [CW-1:0] count, count_next;

  status_e       out_status;
  user_t         out_user;

  // Lookup results from the find unit, valid from the apply step on.
  logic          hit;
  entry_t        found;

  cell_ctrl_t    ctrl;
  entry_t        ents [MAX_TASKS];
  logic [MAX_TASKS-1:0] ahead_v;
  logic [MAX_TASKS-1:0] match_v;

  logic          out_free;
  logic          accept;
  logic          res_load;
  status_e       res_status;
  user_t         res_user;
  logic          full;
  logic          edit_hit;

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = count == CW'(MAX_TASKS);
  assign edit_hit = (req_mode == MODE_EDIT) && hit;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (edit_hit) begin
          state_next = S_INSERT;
        end else if (out_free) begin
          state_next = s_tvalid ? S_LOOK : S_IDLE;
        end
      end
      S_INSERT: begin
        if (out_free) begin
          state_next = s_tvalid ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: handshake, chain command and result.
  always_comb begin
    s_tready      = 1'b0;
    res_load      = 1'b0;
    res_status    = ST_OK;
    res_user      = '0;
    ctrl.op       = CELL_HOLD;
    ctrl.ins      = '{user_id: edit_hit || state == S_INSERT ? found.user_id : req.user_id,
                      task_id: req.task_id, prio: req.prio};
    ctrl.rm_prio  = found.prio;
    ctrl.rm_task  = found.task_id;
    ctrl.look_task = req.task_id;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_LOOK: begin
      end
      S_APPLY: begin
        res_load = out_free && !edit_hit;
        s_tready = out_free && !edit_hit;
        unique case (req_mode)
          MODE_ADD: begin
            if (hit) begin
              res_status = ST_DUPLICATE;
            end else if (full) begin
              res_status = ST_FULL;
            end else if (out_free) begin
              ctrl.op = CELL_INSERT;
            end
          end
          MODE_EDIT: begin
            // The task is taken out here and put back in the reinsert step, once the result can go.
            if (hit) begin
              ctrl.op = CELL_REMOVE;
            end else begin
              res_status = ST_NOT_FOUND;
            end
          end
          MODE_REMOVE: begin
            if (!hit) begin
              res_status = ST_NOT_FOUND;
            end else if (out_free) begin
              ctrl.op = CELL_REMOVE;
            end
          end
          MODE_EXEC: begin
            if (!hit) begin
              res_status = ST_EMPTY;
            end else begin
              res_user = found.user_id;
              if (out_free) begin
                ctrl.op = CELL_REMOVE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_INSERT: begin
        res_load = out_free;
        s_tready = out_free;
        if (out_free) begin
          ctrl.op = CELL_INSERT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctrl.op == CELL_INSERT) begin
      count_next = count + CW'(1);
    end else if (ctrl.op == CELL_REMOVE) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode    <= mode_e'(s_tuser);
      req.user_id <= s_tdata[15:0];
      req.task_id <= s_tdata[31:16];
      req.prio    <= s_tdata[62:32];
    end
    if (res_load) begin
      out_status <= res_status;
      out_user   <= res_user;
    end
  end

  assign m_tdata = {5'b0, out_user, out_status};

  // The sorted chain: cell 0 holds the highest-priority task.
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_a;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_a = 1'b0;
    end else begin : g_body
      assign prev_e = ents[i-1];
      assign prev_a = ahead_v[i-1];
    end
    if (i == MAX_TASKS - 1) begin : g_tail
      assign next_e = ents[i];
    end else begin : g_link
      assign next_e = ents[i+1];
    end
    ipq_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .prev_ent  (prev_e),
      .prev_ahead(prev_a),
      .next_ent  (next_e),
      .ent       (ents[i]),
      .ahead_new (ahead_v[i]),
      .match     (match_v[i])
    );
  end

  // Execute-top takes the head cell; the other modes look the id up.
  ipq_find #(
    .N (MAX_TASKS),
    .CW(CW)
  ) u_find (
    .clk    (clk),
    .load   (state == S_LOOK),
    .top_sel(req_mode == MODE_EXEC),
    .count  (count),
    .match  (match_v),
    .ents   (ents),
    .hit    (hit),
    .found  (found)
  );

  // The fill count never passes the capacity.
  `ASSERT_ALWAYS(a_count_range, count <= CW'(MAX_TASKS))
  // The reinsertion step of an edit always has room.
  `ASSERT_ALWAYS(a_insert_room, state != S_INSERT || count < CW'(MAX_TASKS))
  // An accepted request always starts with its lookup.
  `ASSERT_NEXT(a_accept_look, accept, state == S_LOOK)
  // A finished result is not overwritten while it waits.
  `ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
